/* hdl/ofd_pkg.sv */
// ofd_pkg: shared types, constants and the cell classifier for the
// occupancy frontier detector. No dependencies.
`timescale 1ns / 1ps

package ofd_pkg;

    localparam int CODE_W     = 8;
    localparam int CFG_W      = 11;
    localparam int PT_W       = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [CODE_W-1:0] CODE_FREE = 8'h00;
    localparam logic [CODE_W-1:0] CODE_OCC  = 8'd100;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef enum logic [1:0] {
        CLS_OCC  = 2'd0,
        CLS_UNK  = 2'd1,
        CLS_FREE = 2'd2
    } t_cls;

    // one accepted cell on its way to the window
    typedef struct packed {
        logic            vld;
        logic            check;
        logic            done;
        t_cls            cur;
        logic [PT_W-1:0] pcol;
        logic [PT_W-1:0] prow;
    } t_stage;

    typedef struct packed {
        logic [PT_W-1:0] point_col;
        logic [PT_W-1:0] point_row;
        logic            point_valid;
        logic            grid_done;
    } t_result;

    function automatic t_cls classify(input logic [CODE_W-1:0] code);
        t_cls cls;
        if (code == CODE_FREE) begin
            cls = CLS_FREE;
        end else if (code == CODE_OCC) begin
            cls = CLS_OCC;
        end else begin
            cls = CLS_UNK;
        end
        return cls;
    endfunction

endpackage

/* hdl/ofd_stream_if.sv */
// ofd_cell_if and ofd_point_if: valid/ready channels for cells in and
// frontier results out. Depends on ofd_pkg.
`timescale 1ns / 1ps

interface ofd_cell_if import ofd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CODE_W-1:0] cell_code;

    modport source (output valid, output cell_code, input ready);
    modport sink   (input valid, input cell_code, output ready);
endinterface

interface ofd_point_if import ofd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PT_W-1:0] point_col;
    logic [PT_W-1:0] point_row;
    logic            point_valid;
    logic            grid_done;

    modport source (output valid, output point_col, output point_row,
                    output point_valid, output grid_done, input ready);
    modport sink   (input valid, input point_col, input point_row,
                    input point_valid, input grid_done, output ready);
endinterface

/* hdl/ofd_line_store.sv */
// ofd_line_store: synchronous memory holding the classes of the two previous
// rows per column, with a registered read. Depends on ofd_pkg.
`timescale 1ns / 1ps

module ofd_line_store import ofd_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [3:0]    i_wr_data,
    output logic [3:0]    o_rd_data
);

    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/ofd_window.sv */
// ofd_window: two stored window columns plus the incoming column, frontier
// test on the window center. Depends on ofd_pkg.
`timescale 1ns / 1ps

module ofd_window import ofd_pkg::*; (
    input  logic    i_clk,
    input  t_stage  i_stage,
    input  t_cls    i_up,
    input  t_cls    i_mid,
    output logic    o_push,
    output t_result o_result
);

    t_cls r_left [3];
    t_cls r_ctr  [3];
    t_cls new_col [3];
    logic any_unk;
    logic found;

    always_comb begin
        new_col[0] = i_up;
        new_col[1] = i_mid;
        new_col[2] = i_stage.cur;
        any_unk = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_left[k] == CLS_UNK || r_ctr[k] == CLS_UNK || new_col[k] == CLS_UNK) begin
                any_unk = 1'b1;
            end
        end
        found = i_stage.check && (r_ctr[1] == CLS_FREE) && any_unk;
    end

    always_ff @(posedge i_clk) begin
        if (i_stage.vld) begin
            for (int k = 0; k < 3; k++) begin
                r_left[k] <= r_ctr[k];
                r_ctr[k]  <= new_col[k];
            end
        end
    end

    assign o_push               = i_stage.vld && (found || i_stage.done);
    assign o_result.point_col   = found ? i_stage.pcol : '0;
    assign o_result.point_row   = found ? i_stage.prow : '0;
    assign o_result.point_valid = found;
    assign o_result.grid_done   = i_stage.done;

endmodule

/* hdl/ofd_out_fifo.sv */
// ofd_out_fifo: small result queue that decouples the window from the
// output channel. Depends on ofd_pkg.
`timescale 1ns / 1ps

module ofd_out_fifo import ofd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_data,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* hdl/occupancy_frontier_detector.sv */
// occupancy_frontier_detector: raster scan of occupancy-grid cells with a
// 3x3 window, reports free interior cells next to unknown ones.
// Depends on ofd_pkg, ofd_stream_if, ofd_line_store, ofd_window, ofd_out_fifo.
//
// Usage:
//   Cells enter on i_cell in raster order, one transfer per cell. Results
//   leave on o_point: one transfer per frontier cell, and one flagged with
//   grid_done for the last cell of the grid (both flags may be set at once).
//   Window center (row r-1, col c-1) is judged when cell (r, c) arrives.
//   Each result is registered in r_s1 and then in the result queue before o_point.
//   Throughput: one cell per cycle while i_cell.ready is high, set by the
//   single line store memory port pair (read at transfer, write back in the next cycle).
//   grid_cols/grid_rows live at byte addresses 0 and 4 of the APB port;
//   writes are clamped to 3..MAX_COLS/MAX_ROWS and belong to idle periods.
// Reset: position counters clear, geometry returns to 1024x1024 (clamped
//   to the maximum); the line store is not cleared and needs no sweep.
// Stall: up to four results queue behind o_point; i_cell.ready drops when
//   the queue plus the cell in flight could fill it.
`timescale 1ns / 1ps

module occupancy_frontier_detector import ofd_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ofd_cell_if.sink            i_cell,
    ofd_point_if.source         o_point,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int GCW      = $clog2(MAX_COLS + 1);
    localparam int GRW      = $clog2(MAX_ROWS + 1);
    localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    function automatic logic [GCW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [GCW-1:0] res;
        if (v < CFG_W'(3)) begin
            res = GCW'(3);
        end else if (32'(v) > MAX_COLS) begin
            res = GCW'(MAX_COLS);
        end else begin
            res = GCW'(v);
        end
        return res;
    endfunction

    function automatic logic [GRW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [GRW-1:0] res;
        if (v < CFG_W'(3)) begin
            res = GRW'(3);
        end else if (32'(v) > MAX_ROWS) begin
            res = GRW'(MAX_ROWS);
        end else begin
            res = GRW'(v);
        end
        return res;
    endfunction

    logic [GCW-1:0]     r_grid_cols;
    logic [GRW-1:0]     r_grid_rows;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    t_stage             r_s1;
    logic [CW-1:0]      r_s1_addr;
    logic               cfg_wr;
    logic               accept;
    logic               last_col;
    logic               last_row;
    logic [3:0]         rd_data;
    logic               fifo_push;
    t_result            fifo_in;
    t_result            fifo_out;
    logic               fifo_valid;
    logic [FIFO_CW-1:0] fifo_count;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        if (paddr[2] == REG_ROWS) begin
            prdata = 32'(r_grid_rows);
        end else begin
            prdata = 32'(r_grid_cols);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GCW'(COLS_RST);
            r_grid_rows <= GRW'(ROWS_RST);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COLS) begin
                r_grid_cols <= clamp_cols(pwdata[CFG_W-1:0]);
            end else begin
                r_grid_rows <= clamp_rows(pwdata[CFG_W-1:0]);
            end
        end
    end

    // input transfer and raster position
    assign i_cell.ready = (fifo_count + FIFO_CW'(r_s1.vld)) < FIFO_CW'(FIFO_DEPTH);
    assign accept       = i_cell.valid && i_cell.ready;
    assign last_col     = ((CW+1)'(r_col) + (CW+1)'(1)) >= (CW+1)'(r_grid_cols);
    assign last_row     = ((RW+1)'(r_row) + (RW+1)'(1)) >= (RW+1)'(r_grid_rows);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.check <= (r_row >= RW'(2)) && (r_col >= CW'(2));
            r_s1.done  <= last_col && last_row;
            r_s1.cur   <= classify(i_cell.cell_code);
            r_s1.pcol  <= PT_W'(r_col - CW'(1));
            r_s1.prow  <= PT_W'(r_row - RW'(1));
            r_s1_addr  <= r_col;
        end
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // line store: {row r-2, row r-1} per column, shifted on write back
    ofd_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_s1.vld),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({rd_data[1:0], r_s1.cur}),
        .o_rd_data (rd_data)
    );

    ofd_window u_window (
        .i_clk    (i_clk),
        .i_stage  (r_s1),
        .i_up     (t_cls'(rd_data[3:2])),
        .i_mid    (t_cls'(rd_data[1:0])),
        .o_push   (fifo_push),
        .o_result (fifo_in)
    );

    ofd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (fifo_in),
        .i_pop   (o_point.ready),
        .o_valid (fifo_valid),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    assign o_point.valid       = fifo_valid;
    assign o_point.point_col   = fifo_out.point_col;
    assign o_point.point_row   = fifo_out.point_row;
    assign o_point.point_valid = fifo_out.point_valid;
    assign o_point.grid_done   = fifo_out.grid_done;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> (fifo_count != FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1.vld)
        else $error("accepted cell did not reach the window");

    a_result_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point.valid |-> (o_point.point_valid || o_point.grid_done))
        else $error("empty result on output");

    a_point_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && o_point.point_valid) |->
            (o_point.point_col != '0 && o_point.point_row != '0))
        else $error("frontier point on grid border");

endmodule

/* tb/sv/occupancy_frontier_detector_test.sv */
// occupancy_frontier_detector_test: self-checking bench for the frontier detector,
// directed 3x3 grids, then random grids with mid-grid geometry changes and backpressure.
// Depends on ofd_pkg, ofd_stream_if and the occupancy_frontier_detector RTL.
`timescale 1ns / 1ps

module occupancy_frontier_detector_test;
    import ofd_pkg::*;

    localparam int GRID_MAX      = 1024;
    localparam int GRID_COUNT    = 24;
    localparam int PRESSURE_GRID = 3;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int DIRECTED_ROWS = 18;

    typedef enum {IDLE_NONE, IDLE_SOME, IDLE_FULL} t_idle_mode;
    typedef enum {FILL_MAP, FILL_NOISE} t_fill;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              typed;
        logic              yields;
        t_result           want;
    } t_cell_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ofd_cell_if  cell_ch ();
    ofd_point_if point_ch ();

    occupancy_frontier_detector #(
        .MAX_COLS (GRID_MAX),
        .MAX_ROWS (GRID_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch),
        .o_point (point_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // frontier predictor state
    t_cls        upper_cls [GRID_MAX] = '{default: CLS_OCC};
    t_cls        middle_cls [GRID_MAX] = '{default: CLS_OCC};
    t_cls        win [9] = '{default: CLS_OCC};
    int unsigned cols_cfg = GRID_MAX;
    int unsigned rows_cfg = GRID_MAX;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    t_result     frontier_q [$];
    int unsigned fault_count = 0;
    int unsigned holds_wanted = 0;
    t_idle_mode  src_mode = IDLE_FULL;
    t_idle_mode  sink_mode = IDLE_FULL;

    // two 3x3 grids: free center next to unknowns, then free center with known neighbors
    t_cell_row cell_rows [DIRECTED_ROWS] = '{
        '{CODE_OCC,  1'b1, 1'b0, '0},
        '{8'h80,     1'b1, 1'b0, '0},
        '{CODE_OCC,  1'b1, 1'b0, '0},
        '{8'h7F,     1'b1, 1'b0, '0},
        '{CODE_FREE, 1'b1, 1'b0, '0},
        '{8'hFF,     1'b1, 1'b0, '0},
        '{8'h01,     1'b1, 1'b0, '0},
        '{8'h63,     1'b1, 1'b0, '0},
        '{8'h65,     1'b1, 1'b1, '{10'd1, 10'd1, 1'b1, 1'b1}},
        '{CODE_FREE, 1'b0, 1'b0, '0},
        '{CODE_OCC,  1'b0, 1'b0, '0},
        '{CODE_FREE, 1'b0, 1'b0, '0},
        '{CODE_OCC,  1'b0, 1'b0, '0},
        '{CODE_FREE, 1'b0, 1'b0, '0},
        '{CODE_FREE, 1'b0, 1'b0, '0},
        '{CODE_FREE, 1'b0, 1'b0, '0},
        '{CODE_OCC,  1'b0, 1'b0, '0},
        '{CODE_FREE, 1'b1, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b1}}
    };

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void enqueue_result(input t_result res);
        frontier_q = {frontier_q, res};
    endfunction

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) begin
            return 3;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_cls cell_class(input logic [CODE_W-1:0] code);
        case (code)
            CODE_FREE: return CLS_FREE;
            CODE_OCC:  return CLS_OCC;
            default:   return CLS_UNK;
        endcase
    endfunction

    function automatic int unsigned draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
            default:   return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned hi);
        case ($urandom_range(0, 7))
            0:       return CFG_W'($urandom_range(0, 2));
            1:       return CFG_W'(3);
            default: return CFG_W'($urandom_range(4, hi));
        endcase
    endfunction

    // advances the window by one cell, returns 1 when the cell gives a result
    function automatic bit predict_cell(input logic [CODE_W-1:0] code, output t_result res);
        int unsigned c;
        t_cls        cur;
        t_cls        up;
        t_cls        mid;
        bit          last_col;
        bit          last_row;
        bit          hit;
        c = col_pos % GRID_MAX;
        cur = cell_class(code);
        up = upper_cls[c];
        mid = middle_cls[c];
        last_col = (col_pos + 1 >= cols_cfg);
        last_row = (row_pos + 1 >= rows_cfg);
        for (int k = 0; k < 3; k++) begin
            win[3*k]     = win[3*k + 1];
            win[3*k + 1] = win[3*k + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = cur;
        upper_cls[c] = mid;
        middle_cls[c] = cur;
        hit = 1'b0;
        if (row_pos >= 2 && col_pos >= 2 && win[4] == CLS_FREE) begin
            foreach (win[k]) begin
                if (win[k] == CLS_UNK) begin
                    hit = 1'b1;
                end
            end
        end
        res.point_col   = hit ? PT_W'(col_pos - 1) : '0;
        res.point_row   = hit ? PT_W'(row_pos - 1) : '0;
        res.point_valid = hit;
        res.grid_done   = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return hit || res.grid_done;
    endfunction

    task automatic transfer_cell(input logic [CODE_W-1:0] code, output bit hit,
                                 output t_result res);
        int unsigned gap;
        gap = draw_wait(src_mode);
        if (gap != 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.cell_code <= code;
        do @(posedge i_clk); while (cell_ch.ready !== 1'b1);
        hit = predict_cell(code, res);
    endtask

    task automatic feed_cell(input t_fill fill);
        logic [CODE_W-1:0] code;
        bit                hit;
        t_result           res;
        code = CODE_W'($urandom_range(0, 255));
        if (fill == FILL_MAP) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: code = CODE_FREE;
                5, 6, 7:       code = CODE_OCC;
                default:       ;
            endcase
        end
        transfer_cell(code, hit, res);
        if (hit) begin
            enqueue_result(res);
        end
    endtask

    task automatic finish_grid(input t_fill fill);
        do feed_cell(fill); while (col_pos != 0 || row_pos != 0);
    endtask

    // idle the input, wait for every expected result, then let the pipeline empty
    task automatic settle();
        int unsigned waited;
        cell_ch.valid <= 1'b0;
        waited = 0;
        while (frontier_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (frontier_q.size() != 0) begin
            log_fault($sformatf("%0d expected results never arrived", frontier_q.size()));
            frontier_q.delete();
        end
    endtask

    // optional write with random upper bits, then read back the stored value
    task automatic program_reg(input logic idx, input logic [CFG_W-1:0] value,
                               input bit do_write);
        logic [31:0] word;
        int unsigned held;
        word = $urandom();
        if ($urandom_range(0, 1) == 0) begin
            word[31:CFG_W] = '0;
        end
        word[CFG_W-1:0] = value;
        if (do_write) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= word;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            if (idx == REG_COLS) begin
                cols_cfg = fit_dim(value, GRID_MAX);
            end else begin
                rows_cfg = fit_dim(value, GRID_MAX);
            end
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        held = (idx == REG_COLS) ? cols_cfg : rows_cfg;
        if (prdata !== 32'(held)) begin
            log_fault($sformatf("register %0d readback: expected %0d got %0d",
                                idx, held, prdata));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold on request, in-order compare
    initial begin
        int unsigned holds_done;
        int unsigned gap;
        t_result     want;
        t_result     got;
        holds_done = 0;
        point_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holds_done < holds_wanted) begin
                holds_done++;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_wait(sink_mode);
            end
            if (gap != 0) begin
                point_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge i_clk); while (point_ch.valid !== 1'b1);
            got.point_col   = point_ch.point_col;
            got.point_row   = point_ch.point_row;
            got.point_valid = point_ch.point_valid;
            got.grid_done   = point_ch.grid_done;
            if (frontier_q.size() == 0) begin
                log_fault($sformatf("unexpected result col=%0d row=%0d pv=%0b done=%0b",
                                    got.point_col, got.point_row, got.point_valid,
                                    got.grid_done));
            end else begin
                want = frontier_q.pop_front();
                if (got.point_col !== want.point_col || got.point_row !== want.point_row ||
                    got.point_valid !== want.point_valid ||
                    got.grid_done !== want.grid_done) begin
                    log_fault($sformatf({"result mismatch: expected col=%0d row=%0d pv=%0b ",
                                         "done=%0b, got col=%0d row=%0d pv=%0b done=%0b"},
                                        want.point_col, want.point_row, want.point_valid,
                                        want.grid_done, got.point_col, got.point_row,
                                        got.point_valid, got.grid_done));
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        bit      hit;
        t_result res;
        t_fill   fill;
        cell_ch.valid <= 1'b0;
        cell_ch.cell_code <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, then undersized values that clamp to the minimum
        program_reg(REG_COLS, '0, 1'b0);
        program_reg(REG_ROWS, '0, 1'b0);
        program_reg(REG_COLS, CFG_W'(0), 1'b1);
        program_reg(REG_ROWS, CFG_W'(1), 1'b1);
        foreach (cell_rows[i]) begin
            transfer_cell(cell_rows[i].code, hit, res);
            if (cell_rows[i].typed) begin
                if (cell_rows[i].yields) begin
                    enqueue_result(cell_rows[i].want);
                end
            end else if (hit) begin
                enqueue_result(res);
            end
        end
        settle();

        for (int g = 0; g < GRID_COUNT; g++) begin
            src_mode = t_idle_mode'($urandom_range(0, 2));
            sink_mode = t_idle_mode'($urandom_range(0, 2));
            fill = ($urandom_range(0, 6) == 0) ? FILL_NOISE : FILL_MAP;
            if (g == PRESSURE_GRID) begin
                // sender keeps offering while the result side holds off
                src_mode = IDLE_NONE;
                fill = FILL_MAP;
                holds_wanted++;
                program_reg(REG_COLS, CFG_W'(20), 1'b1);
                program_reg(REG_ROWS, CFG_W'(10), 1'b1);
            end else begin
                program_reg(REG_COLS, pick_dim(20), 1'b1);
                program_reg(REG_ROWS, pick_dim(10), 1'b1);
            end
            finish_grid(fill);
            settle();
        end

        // widest row clamps to the maximum, then shrinks mid-row
        src_mode = IDLE_SOME;
        sink_mode = IDLE_SOME;
        program_reg(REG_COLS, CFG_W'(2047), 1'b1);
        program_reg(REG_ROWS, CFG_W'(3), 1'b1);
        repeat (40) feed_cell(FILL_MAP);
        settle();
        program_reg(REG_COLS, CFG_W'(6), 1'b1);
        finish_grid(FILL_MAP);
        settle();

        // tallest grid clamps to the maximum, then shrinks below the current row
        program_reg(REG_COLS, CFG_W'(3), 1'b1);
        program_reg(REG_ROWS, CFG_W'(1500), 1'b1);
        repeat (24) feed_cell(FILL_MAP);
        settle();
        program_reg(REG_ROWS, CFG_W'(5), 1'b1);
        finish_grid(FILL_MAP);
        settle();

        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
